// File: rtl/core/nlt_pkg.sv
// Shared types and constants of the node lock table.
package nlt_pkg;

    // Field widths of the request and result beats
    localparam int OP_W        = 4;
    localparam int NODE_W      = 10;
    localparam int THR_W       = 4;
    localparam int WORD_OUT_W  = 18;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Reader bits start above the writer and pending bits
    localparam int READ_OFF = 2;

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INS_WR_TRY      = 4'd0,
        OP_INS_RD_TRY      = 4'd1,
        OP_INS_WR_REL      = 4'd2,
        OP_INS_RD_REL      = 4'd3,
        OP_DEGRADE         = 4'd4,
        OP_INS_RM_INTENT   = 4'd5,
        OP_INS_RM_COMPLETE = 4'd6,
        OP_INS_RM_REL      = 4'd7,
        OP_RM_RD_ACQ       = 4'd8,
        OP_RM_RD_REL       = 4'd9,
        OP_RM_WR_INTENT    = 4'd10,
        OP_RM_WR_COMPLETE  = 4'd11,
        OP_RM_WR_NOWAIT    = 4'd12,
        OP_RM_WR_REL       = 4'd13,
        OP_COMB_REL        = 4'd14
    } t_op;

    // Classified request as it waits in the queue
    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] node;
        logic [THR_W-1:0]  thread;
        logic              node_ok;
        logic              thread_ok;
    } t_cmd;

    // Back-pressure seen by the front
    typedef struct packed {
        logic q_full;
        logic clearing;
    } t_gate;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

endpackage

// File: rtl/core/nlt_front.sv
// Request front: input handshake, field unpacking and range classification.
module nlt_front
    import nlt_pkg::*;
#(
    parameter int NODES   = 1024,
    parameter int THREADS = 16
) (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // op[3:0], node_index[13:4], thread[17:14]
    input  t_gate                 i_gate,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [OP_W-1:0]   op_raw;
    logic [NODE_W-1:0] node;
    logic [THR_W-1:0]  thread;

    // Unpack the request beat
    assign op_raw = s_axis_tdata[OP_W-1:0];
    assign node   = s_axis_tdata[OP_W+NODE_W-1:OP_W];
    assign thread = s_axis_tdata[OP_W+NODE_W+THR_W-1:OP_W+NODE_W];

    // Hold off while the queue is full or the table is being cleared
    assign s_axis_tready = !i_gate.q_full && !i_gate.clearing;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    // Classify node and thread against the table size
    always_comb begin
        o_cmd.op        = t_op'(op_raw);
        o_cmd.node      = node;
        o_cmd.thread    = thread;
        o_cmd.node_ok   = 32'(node) < 32'(NODES);
        o_cmd.thread_ok = 32'(thread) < 32'(THREADS);
    end

endmodule

// File: rtl/core/nlt_queue.sv
// Two-entry request queue between the front and the back.
module nlt_queue
    import nlt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_cmd   = r_mem[r_rptr];

    // Advance pointers and fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/nlt_back.sv
// Lock back end: word memories, clearing sweep, read-modify-write and result register.
module nlt_back
    import nlt_pkg::*;
#(
    parameter int NODES   = 1024,
    parameter int THREADS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_cmd                   i_q_cmd,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata  // granted[0], insert_word_after[18:1],
                                                 // remove_word_after[36:19]
);

    localparam int W  = THREADS + READ_OFF;
    localparam int AW = $clog2(NODES);

    t_back_state     r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    t_cmd            r_cmd, n_cmd;

    logic [W-1:0]    r_iw_mem [NODES];
    logic [W-1:0]    r_rw_mem [NODES];
    logic [W-1:0]    r_iw_rd, r_rw_rd;

    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [W-1:0]    iw_wdata, rw_wdata;

    logic            out_load;
    logic            r_out_valid;
    logic            r_granted;
    logic [WORD_OUT_W-1:0] r_iw_out, r_rw_out;

    logic [W-1:0]    rd_mask;
    logic [W-1:0]    iw_new, rw_new;
    logic            g_new;

    // Reader bit of the requesting thread
    assign rd_mask = W'(1) << ({1'b0, r_cmd.thread} + (THR_W + 1)'(READ_OFF));

    // Apply one lock operation to the words just read
    always_comb begin
        iw_new = r_iw_rd;
        rw_new = r_rw_rd;
        g_new  = 1'b0;
        case (r_cmd.op)
            OP_INS_WR_TRY: begin
                if (r_iw_rd == '0) begin
                    iw_new = W'(1);
                    g_new  = 1'b1;
                end
            end
            OP_INS_RD_TRY: begin
                if (r_iw_rd[1:0] == 2'b00) begin
                    iw_new = r_iw_rd | rd_mask;
                    g_new  = 1'b1;
                end
            end
            OP_INS_WR_REL: begin
                iw_new = r_iw_rd & ~W'(1);
                g_new  = 1'b1;
            end
            OP_INS_RD_REL: begin
                iw_new = r_iw_rd & ~rd_mask;
                g_new  = 1'b1;
            end
            OP_DEGRADE: begin
                iw_new = rd_mask | (r_iw_rd & W'(2));
                g_new  = 1'b1;
            end
            OP_INS_RM_INTENT: begin
                if (!r_iw_rd[1]) begin
                    iw_new = r_iw_rd | W'(2);
                    g_new  = 1'b1;
                end
            end
            OP_INS_RM_COMPLETE: begin
                if (r_iw_rd == W'(2)) begin
                    iw_new = W'(3);
                    g_new  = 1'b1;
                end
            end
            OP_INS_RM_REL: begin
                if (r_iw_rd == W'(3)) begin
                    iw_new = '0;
                    g_new  = 1'b1;
                end
            end
            OP_RM_RD_ACQ: begin
                if (!r_rw_rd[0]) begin
                    rw_new = r_rw_rd | rd_mask;
                    g_new  = 1'b1;
                end
            end
            OP_RM_RD_REL: begin
                rw_new = r_rw_rd & ~rd_mask;
                g_new  = 1'b1;
            end
            OP_RM_WR_INTENT: begin
                if (!r_rw_rd[0]) begin
                    rw_new = r_rw_rd | W'(1);
                    g_new  = 1'b1;
                end
            end
            OP_RM_WR_COMPLETE: begin
                if (r_rw_rd == W'(1)) begin
                    rw_new = W'(3);
                    g_new  = 1'b1;
                end else begin
                    rw_new = r_rw_rd | W'(1);
                end
            end
            OP_RM_WR_NOWAIT: begin
                if (r_rw_rd == '0) begin
                    rw_new = W'(3);
                    g_new  = 1'b1;
                end
            end
            OP_RM_WR_REL: begin
                if (r_rw_rd == W'(3)) begin
                    rw_new = '0;
                    g_new  = 1'b1;
                end
            end
            OP_COMB_REL: begin
                iw_new = r_iw_rd & ~W'(1);
                rw_new = r_rw_rd & ~rd_mask;
                g_new  = 1'b1;
            end
            default: begin
                g_new = 1'b0;
            end
        endcase
    end

    // Sequence clearing, request fetch and the read-modify-write
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cmd      = r_cmd;
        o_pop      = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = AW'(r_cmd.node);
        iw_wdata   = iw_new;
        rw_wdata   = rw_new;
        out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                iw_wdata   = '0;
                rw_wdata   = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    mem_re  = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    mem_we   = r_cmd.node_ok && r_cmd.thread_ok;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_clearing = r_state == ST_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Lock word memories with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_iw_mem[mem_waddr] <= iw_wdata;
            r_rw_mem[mem_waddr] <= rw_wdata;
        end
        if (mem_re) begin
            r_iw_rd <= r_iw_mem[AW'(i_q_cmd.node)];
            r_rw_rd <= r_rw_mem[AW'(i_q_cmd.node)];
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (!r_cmd.node_ok) begin
                r_granted <= 1'b0;
                r_iw_out  <= '0;
                r_rw_out  <= '0;
            end else if (!r_cmd.thread_ok) begin
                r_granted <= 1'b0;
                r_iw_out  <= WORD_OUT_W'(r_iw_rd);
                r_rw_out  <= WORD_OUT_W'(r_rw_rd);
            end else begin
                r_granted <= g_new;
                r_iw_out  <= WORD_OUT_W'(iw_new);
                r_rw_out  <= WORD_OUT_W'(rw_new);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 1 - 2 * WORD_OUT_W){1'b0}},
                            r_rw_out, r_iw_out, r_granted};

    // Checks on sequencing and write gating
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_pop)
        else $error("request fetched during clearing sweep");

    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_EXEC))
        else $error("fetched request not executed next cycle");

    a_load_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == ST_EXEC))
        else $error("result loaded outside execute step");

    a_write_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == ST_EXEC) |-> (r_cmd.node_ok && r_cmd.thread_ok))
        else $error("lock word written for out-of-range request");

endmodule

// File: rtl/core/node_lock_table.sv
// Top level of the node lock table: front, request queue and lock back end.
//
//  Channel  Dir  Data bits  Fields (low bit up)
//  s_axis   in   24         op[3:0], node_index[13:4], thread[17:14]
//  m_axis   out  40         granted[0], insert_word_after[18:1], remove_word_after[36:19]
//
// Each request passes through the back end as a memory read issued from ST_IDLE, then a
// modify-write in ST_EXEC that also loads the result register once it is free; the next
// read is issued only after the write-back, with no forwarding.
// After reset a clearing sweep zeroes every address of both word memories; s_axis_tready
// stays low until it ends.
// A two-beat queue takes requests while the back end works or waits on m_axis_tready.
module node_lock_table
    import nlt_pkg::*;
#(
    parameter int NODES   = 1024,
    parameter int THREADS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // op[3:0], node_index[13:4], thread[17:14]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // granted[0], insert_word_after[18:1],
                                                  // remove_word_after[36:19]
);

    t_gate gate;
    logic  push, pop, q_valid, q_full, clearing;
    t_cmd  push_cmd, head_cmd;

    assign gate.q_full   = q_full;
    assign gate.clearing = clearing;

    nlt_front #(
        .NODES   (NODES),
        .THREADS (THREADS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_gate        (gate),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    nlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    nlt_back #(
        .NODES   (NODES),
        .THREADS (THREADS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (head_cmd),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the node lock table: directed ops, random lock traffic, stalls.
module tb
    import nlt_pkg::*;
();

    localparam int NODES        = 1024;
    localparam int THREADS      = 16;
    localparam int WORD_W       = THREADS + READ_OFF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    // Operation code that the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 4'd15;

    // One result beat as predicted
    typedef struct packed {
        logic [WORD_W-1:0] rem_word;
        logic [WORD_W-1:0] ins_word;
        logic              granted;
    } t_lock_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // op[3:0], node_index[13:4], thread[17:14]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // granted[0], insert_word_after[18:1],
                                                 // remove_word_after[36:19]

    // Predicted lock words, cleared like the block after reset
    logic [WORD_W-1:0] ins_words [NODES] = '{default: '0};
    logic [WORD_W-1:0] rem_words [NODES] = '{default: '0};

    t_lock_result expected_words [$];

    int err_cnt       = 0;
    int sent_cnt      = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_cnt  = 0;
    int hold_ack_cnt  = 0;
    int hold_left     = 0;

    node_lock_table #(
        .NODES   (NODES),
        .THREADS (THREADS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Toggle the clock
    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("node_lock_table test failed");
            $finish;
        end
    end

    // Apply one request to the predicted words and return the result beat
    function automatic t_lock_result apply_lock_op(input logic [OP_W-1:0] op,
                                                   input logic [NODE_W-1:0] node,
                                                   input logic [THR_W-1:0] thr);
        t_lock_result      res;
        logic [WORD_W-1:0] iw;
        logic [WORD_W-1:0] rw;
        logic [WORD_W-1:0] rd;
        logic              g;
        // Node and thread are always in range at these widths
        iw = ins_words[node];
        rw = rem_words[node];
        rd = WORD_W'(1) << (thr + READ_OFF);
        g  = 1'b0;
        case (op)
            OP_INS_WR_TRY:      if (iw == '0) begin iw = WORD_W'(1); g = 1'b1; end
            OP_INS_RD_TRY:      if (iw[1:0] == 2'b00) begin iw = iw | rd; g = 1'b1; end
            OP_INS_WR_REL:      begin iw[0] = 1'b0; g = 1'b1; end
            OP_INS_RD_REL:      begin iw = iw & ~rd; g = 1'b1; end
            OP_DEGRADE:         begin iw = rd | (iw & WORD_W'(2)); g = 1'b1; end
            OP_INS_RM_INTENT:   if (!iw[1]) begin iw[1] = 1'b1; g = 1'b1; end
            OP_INS_RM_COMPLETE: if (iw == WORD_W'(2)) begin iw = WORD_W'(3); g = 1'b1; end
            OP_INS_RM_REL:      if (iw == WORD_W'(3)) begin iw = '0; g = 1'b1; end
            OP_RM_RD_ACQ:       if (!rw[0]) begin rw = rw | rd; g = 1'b1; end
            OP_RM_RD_REL:       begin rw = rw & ~rd; g = 1'b1; end
            OP_RM_WR_INTENT:    if (!rw[0]) begin rw[0] = 1'b1; g = 1'b1; end
            OP_RM_WR_COMPLETE: begin
                // A miss sets the intent bit again
                if (rw == WORD_W'(1)) begin
                    rw = WORD_W'(3);
                    g  = 1'b1;
                end else begin
                    rw[0] = 1'b1;
                end
            end
            OP_RM_WR_NOWAIT:    if (rw == '0) begin rw = WORD_W'(3); g = 1'b1; end
            OP_RM_WR_REL:       if (rw == WORD_W'(3)) begin rw = '0; g = 1'b1; end
            OP_COMB_REL:        begin iw[0] = 1'b0; rw = rw & ~rd; g = 1'b1; end
            default: ;
        endcase
        ins_words[node] = iw;
        rem_words[node] = rw;
        res.granted  = g;
        res.ins_word = iw;
        res.rem_word = rw;
        return res;
    endfunction

    // Offer one request beat, wait for acceptance, record its expected result
    task automatic send_req(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                            input logic [THR_W-1:0] thr, output logic granted);
        t_lock_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - OP_W - NODE_W - THR_W){1'b0}}, thr, node, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = apply_lock_op(op, node, thr);
        expected_words.push_back(res);
        granted = res.granted;
        if (op != OP_UNUSED) sent_cnt++;
    endtask

    // Drive the result side: random idling, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt  <= hold_req_cnt;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_lock_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                err_cnt++;
            end else begin
                exp_r = expected_words.pop_front();
                if (m_axis_tdata[0] !== exp_r.granted) begin
                    $error("granted: expected %0d, actual %0d", exp_r.granted, m_axis_tdata[0]);
                    err_cnt++;
                end
                if (m_axis_tdata[WORD_OUT_W:1] !== exp_r.ins_word) begin
                    $error("insert_word_after: expected %h, actual %h",
                           exp_r.ins_word, m_axis_tdata[WORD_OUT_W:1]);
                    err_cnt++;
                end
                if (m_axis_tdata[2*WORD_OUT_W:WORD_OUT_W+1] !== exp_r.rem_word) begin
                    $error("remove_word_after: expected %h, actual %h",
                           exp_r.rem_word, m_axis_tdata[2*WORD_OUT_W:WORD_OUT_W+1]);
                    err_cnt++;
                end
            end
        end
    end

    // Walk every operation on one node; all but the refused insert read try are granted
    task automatic test_all_ops();
        logic g;
        send_req(OP_INS_WR_TRY,      10'd5, 4'd3, g);
        send_req(OP_INS_RD_TRY,      10'd5, 4'd3, g);  // refused: writer holds
        send_req(OP_DEGRADE,         10'd5, 4'd3, g);
        send_req(OP_INS_RD_REL,      10'd5, 4'd3, g);
        send_req(OP_INS_RM_INTENT,   10'd5, 4'd3, g);
        send_req(OP_INS_RM_COMPLETE, 10'd5, 4'd3, g);
        send_req(OP_INS_RM_REL,      10'd5, 4'd3, g);
        send_req(OP_INS_WR_REL,      10'd5, 4'd3, g);
        send_req(OP_RM_RD_ACQ,       10'd5, 4'd3, g);
        send_req(OP_RM_RD_REL,       10'd5, 4'd3, g);
        send_req(OP_RM_WR_INTENT,    10'd5, 4'd3, g);
        send_req(OP_RM_WR_COMPLETE,  10'd5, 4'd3, g);
        send_req(OP_RM_WR_REL,       10'd5, 4'd3, g);
        send_req(OP_RM_WR_NOWAIT,    10'd5, 4'd3, g);
        send_req(OP_COMB_REL,        10'd5, 4'd3, g);
        send_req(OP_RM_WR_REL,       10'd5, 4'd3, g);
    endtask

    // Hit the lowest and highest node and thread
    task automatic test_field_extremes();
        logic g;
        send_req(OP_INS_RD_TRY, 10'd0,    4'd0,  g);
        send_req(OP_INS_RD_TRY, 10'd1023, 4'd15, g);
        send_req(OP_INS_RD_TRY, 10'd1023, 4'd0,  g);
        send_req(OP_RM_RD_ACQ,  10'd1023, 4'd15, g);
        send_req(OP_COMB_REL,   10'd1023, 4'd15, g);
        send_req(OP_INS_RD_REL, 10'd0,    4'd0,  g);
    endtask

    // Unused op code, and a remove-write complete that misses then succeeds
    task automatic test_special_cases();
        logic g;
        send_req(OP_UNUSED,         10'd5, 4'd3, g);
        send_req(OP_RM_WR_COMPLETE, 10'd7, 4'd9, g);
        send_req(OP_RM_WR_COMPLETE, 10'd7, 4'd9, g);
    endtask

    // Mostly a few hot nodes so requests collide, sometimes the last node or any node
    function automatic logic [NODE_W-1:0] pick_node();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return NODE_W'($urandom_range(0, 3));
        if (r == 7) return NODE_W'(NODES - 1);
        return NODE_W'($urandom_range(0, NODES - 1));
    endfunction

    // Release whatever the node still holds, as seen by the predictor
    task automatic release_node(input logic [NODE_W-1:0] n);
        logic g;
        for (int b = 0; b < THREADS; b++)
            if (ins_words[n][b + READ_OFF]) send_req(OP_INS_RD_REL, n, THR_W'(b), g);
        if (ins_words[n][0]) send_req(OP_INS_WR_REL, n, 4'd0, g);
        if (ins_words[n][1]) begin
            send_req(OP_INS_RM_COMPLETE, n, 4'd0, g);
            send_req(OP_INS_RM_REL,      n, 4'd0, g);
        end
        for (int b = 0; b < THREADS; b++)
            if (rem_words[n][b + READ_OFF])
                send_req($urandom_range(0, 1) ? OP_RM_RD_REL : OP_COMB_REL, n, THR_W'(b), g);
        if (rem_words[n][1:0] == 2'b01) send_req(OP_RM_WR_COMPLETE, n, 4'd0, g);
        if (rem_words[n][1:0] == 2'b11) send_req(OP_RM_WR_REL, n, 4'd0, g);
    endtask

    // One lock usage pattern with random node and threads, noise, or a release of the node
    task automatic run_lock_sequence();
        logic [NODE_W-1:0] n;
        logic [THR_W-1:0]  t;
        logic [THR_W-1:0]  t2;
        logic              g;
        int                kind;
        n    = pick_node();
        t    = THR_W'($urandom_range(0, THREADS - 1));
        t2   = THR_W'($urandom_range(0, THREADS - 1));
        kind = $urandom_range(0, 11);
        case (kind)
            0: begin
                send_req(OP_INS_RD_TRY, n, t, g);
                if (g) send_req(OP_INS_RD_REL, n, t, g);
            end
            1: begin
                send_req(OP_INS_WR_TRY, n, t, g);
                if (g) begin
                    if ($urandom_range(0, 1)) begin
                        send_req(OP_INS_WR_REL, n, t, g);
                    end else begin
                        send_req(OP_DEGRADE,    n, t, g);
                        send_req(OP_INS_RD_REL, n, t, g);
                    end
                end
            end
            2: begin
                send_req(OP_INS_RM_INTENT, n, t, g);
                if (g) begin
                    send_req(OP_INS_RM_COMPLETE, n, t, g);
                    if (g) send_req(OP_INS_RM_REL, n, t, g);
                end
            end
            3: begin
                send_req(OP_RM_RD_ACQ, n, t, g);
                if (g) send_req($urandom_range(0, 1) ? OP_RM_RD_REL : OP_COMB_REL, n, t, g);
            end
            4: begin
                send_req(OP_RM_WR_INTENT, n, t, g);
                if (g) begin
                    send_req(OP_RM_WR_COMPLETE, n, t, g);
                    if (g) send_req(OP_RM_WR_REL, n, t, g);
                end
            end
            5: begin
                send_req(OP_RM_WR_NOWAIT, n, t, g);
                if (g) send_req(OP_RM_WR_REL, n, t, g);
            end
            6: begin
                // Two readers block a writer until both leave
                send_req(OP_INS_RD_TRY, n, t,  g);
                send_req(OP_INS_RD_TRY, n, t2, g);
                send_req(OP_INS_WR_TRY, n, t,  g);
                send_req(OP_INS_RD_REL, n, t,  g);
                send_req(OP_INS_RD_REL, n, t2, g);
                send_req(OP_INS_WR_TRY, n, t,  g);
                if (g) send_req(OP_INS_WR_REL, n, t, g);
            end
            7: begin
                // Remove writer waits out a remove reader
                send_req(OP_RM_RD_ACQ,    n, t,  g);
                send_req(OP_RM_WR_INTENT, n, t2, g);
                if (g) begin
                    send_req(OP_RM_WR_COMPLETE, n, t2, g);
                    send_req(OP_RM_RD_REL,      n, t,  g);
                    send_req(OP_RM_WR_COMPLETE, n, t2, g);
                    if (g) send_req(OP_RM_WR_REL, n, t2, g);
                end else begin
                    send_req(OP_RM_RD_REL, n, t, g);
                end
            end
            8, 9: send_req(OP_W'($urandom_range(0, 15)), n, t, g);
            10:   send_req(OP_W'($urandom_range(0, 15)),
                           NODE_W'($urandom_range(0, NODES - 1)), t, g);
            default: release_node(n);
        endcase
    endtask

    // Random lock traffic until the given number of requests is sent
    task automatic test_random_traffic(input int n_items);
        int start;
        start = sent_cnt;
        while (sent_cnt - start < n_items) run_lock_sequence();
    endtask

    // Hold off the result side while requests keep coming, filling the block
    task automatic test_input_stall();
        hold_req_cnt++;
        test_random_traffic(40);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 56;
        test_all_ops();
        test_field_extremes();
        test_special_cases();
        test_random_traffic(340);

        send_idle_pct = 56;
        recv_idle_pct = 25;
        test_random_traffic(340);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_input_stall();
        test_random_traffic(300);

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("node_lock_table test passed");
        end else begin
            $display("node_lock_table test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/nlt_pkg.sv
rtl/core/nlt_front.sv
rtl/core/nlt_queue.sv
rtl/core/nlt_back.sv
rtl/core/node_lock_table.sv
sim/tb.sv
